### src/txg_pkg.sv
// ---------------------------------------------------------------------------
// txg_pkg: shared types and constants for the text glyph row renderer
// Opcodes, register indexes, configuration and queue-entry types, helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package txg_pkg;

  localparam int GLYPH_WORDS = 4096;
  localparam int CHAR_SET    = 256;
  localparam int GW_AW       = $clog2(GLYPH_WORDS);
  localparam int CS_AW       = $clog2(CHAR_SET);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // input opcodes
  localparam logic [1:0] OP_START      = 2'd0;
  localparam logic [1:0] OP_CHAR       = 2'd1;
  localparam logic [1:0] OP_LOAD_ROW   = 2'd2;
  localparam logic [1:0] OP_LOAD_START = 2'd3;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // configuration register indexes
  localparam logic [2:0] CFG_LINE_PITCH   = 3'd0;
  localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_RIGHT_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_PORTRAIT     = 3'd4;
  localparam logic [2:0] CFG_FORE_COLOR   = 3'd5;
  localparam logic [2:0] CFG_BACK_COLOR   = 3'd6;
  localparam logic [2:0] CFG_KEEP_BEHIND  = 3'd7;

  typedef struct packed {
    logic [12:0] line_pitch;
    logic [4:0]  glyph_width;
    logic [4:0]  glyph_height;
    logic [12:0] right_limit;
    logic        portrait_layout;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic        keep_behind;
  } txg_cfg_t;

  // front-to-back work entry; kind reuses the opcode codes
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] index;   // store word, table entry, or char code in [7:0]
    logic [15:0] data;
    logic [12:0] col;
    logic [12:0] row;
  } txg_entry_t;

  // zero counts as 1, above 16 counts as 16
  function automatic logic [4:0] clamp_size(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0)       r = 5'd1;
    else if (v > 5'd16)  r = 5'd16;
    return r;
  endfunction

  // top w bits set, w in 1..16
  function automatic logic [15:0] glyph_mask(input logic [4:0] w);
    logic [15:0] r;
    r = ~(16'hFFFF >> w);
    return r;
  endfunction

endpackage

`default_nettype wire

### src/txg_if.sv
// ---------------------------------------------------------------------------
// txg_if: channel interfaces for the text glyph row renderer
// Input word channel and row-command result channel, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface txg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic [11:0] start_x;
  logic [11:0] start_y;
  logic [11:0] table_index;
  logic [15:0] table_data;

  modport source (output valid, opcode, char_code, start_x, start_y, table_index,
                  table_data, input ready);
  modport sink   (input valid, opcode, char_code, start_x, start_y, table_index,
                  table_data, output ready);
endinterface

interface txg_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] row_address;
  logic [4:0]  pixel_count;
  logic [15:0] fore_mask;
  logic        step_by_pitch;
  logic [15:0] fore_value;
  logic [15:0] back_value;
  logic        copy_behind;
  logic        last_row;

  modport source (output valid, row_address, pixel_count, fore_mask, step_by_pitch,
                  fore_value, back_value, copy_behind, last_row, input ready);
  modport sink   (input valid, row_address, pixel_count, fore_mask, step_by_pitch,
                  fore_value, back_value, copy_behind, last_row, output ready);
endinterface

`default_nettype wire

### src/txg_front.sv
// ---------------------------------------------------------------------------
// txg_front: input classifier
// Tracks cursor, line start and halt; turns draws and loads into queue entries.
// ---------------------------------------------------------------------------
`default_nettype none

module txg_front (
  input  logic                clk,
  input  logic                rst_n,
  txg_in_if.sink              in_chan,
  input  txg_pkg::txg_cfg_t   cfg,
  output txg_pkg::txg_entry_t push_entry,
  output logic                push_valid,
  input  logic                push_ready
);
  import txg_pkg::*;

  logic [12:0] cursor_col_r, cursor_col_nxt;
  logic [12:0] cursor_row_r, cursor_row_nxt;
  logic [11:0] line_origin_r, line_origin_nxt;
  logic        halted_r, halted_nxt;

  logic        accept;
  logic [4:0]  w, h;
  logic        crosses;

  assign in_chan.ready = push_ready;
  assign accept = in_chan.valid && push_ready;

  assign w = clamp_size(cfg.glyph_width);
  assign h = clamp_size(cfg.glyph_height);
  assign crosses = ({1'b0, cursor_col_r} + 14'(w)) > {1'b0, cfg.right_limit};

  always_comb begin
    cursor_col_nxt  = cursor_col_r;
    cursor_row_nxt  = cursor_row_r;
    line_origin_nxt = line_origin_r;
    halted_nxt      = halted_r;
    push_valid      = 1'b0;

    push_entry.kind  = in_chan.opcode;
    push_entry.index = in_chan.table_index;
    push_entry.data  = in_chan.table_data;
    push_entry.col   = cursor_col_r;
    push_entry.row   = cursor_row_r;

    if (accept) begin
      unique case (in_chan.opcode)
        OP_START: begin
          line_origin_nxt = in_chan.start_x;
          cursor_col_nxt  = 13'(in_chan.start_x);
          cursor_row_nxt  = 13'(in_chan.start_y);
          halted_nxt      = 1'b0;
        end
        OP_LOAD_ROW: begin
          push_valid = 1'b1;
        end
        OP_LOAD_START: begin
          // entries beyond the character set are dropped
          push_valid = (in_chan.table_index < 12'(CHAR_SET));
        end
        OP_CHAR: begin
          push_entry.index = 12'(in_chan.char_code);
          if (!halted_r) begin
            if (in_chan.char_code == NEWLINE_CODE) begin
              cursor_row_nxt = cursor_row_r + 13'(h);
              cursor_col_nxt = 13'(line_origin_r);
            end else if (crosses) begin
              halted_nxt = 1'b1;
            end else begin
              push_valid     = 1'b1;
              cursor_col_nxt = cursor_col_r + 13'(w);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r  <= '0;
      cursor_row_r  <= '0;
      line_origin_r <= '0;
      halted_r      <= 1'b1;
    end else begin
      cursor_col_r  <= cursor_col_nxt;
      cursor_row_r  <= cursor_row_nxt;
      line_origin_r <= line_origin_nxt;
      halted_r      <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

### src/txg_queue.sv
// ---------------------------------------------------------------------------
// txg_queue: short entry queue between front and back
// Register-based FIFO of work entries.
// ---------------------------------------------------------------------------
`default_nettype none

module txg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  txg_pkg::txg_entry_t push_entry,
  input  logic                push_valid,
  output logic                push_ready,
  output txg_pkg::txg_entry_t pop_entry,
  output logic                pop_valid,
  input  logic                pop_take
);
  import txg_pkg::*;

  txg_entry_t      slot_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != (Q_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_take && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      // push and pop together leave the count alone
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

### src/txg_back.sv
// ---------------------------------------------------------------------------
// txg_back: glyph memories and row sequencer
// Applies table loads, looks up glyphs and emits one row command per cycle while out_chan is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module txg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  txg_pkg::txg_cfg_t   cfg,
  input  txg_pkg::txg_entry_t q_entry,
  input  logic                q_valid,
  output logic                q_take,
  txg_out_if.source           out_chan
);
  import txg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_ROWS = 2'd2;

  logic [15:0] glyph_store [GLYPH_WORDS];
  logic [11:0] glyph_start [CHAR_SET];

  logic [1:0]       state_r, state_nxt;
  logic [12:0]      col_r, row_r;
  logic [25:0]      prod_r;
  logic [11:0]      start_rd_r;
  logic [15:0]      word_rd_r;
  logic [4:0]       row_i_r;
  logic [23:0]      row_addr_r;
  logic             fet_valid_r;
  logic [23:0]      fet_addr_r;
  logic             fet_last_r;
  logic             out_valid_r;
  logic [23:0]      out_addr_r;
  logic [15:0]      out_mask_r;
  logic             out_last_r;

  logic [4:0]       w, h;
  logic             advance, issue, is_draw;
  logic             store_we, start_we, start_re;
  logic [GW_AW-1:0] store_ra;
  logic [12:0]      mul_a;
  logic [23:0]      step;

  assign w       = clamp_size(cfg.glyph_width);
  assign h       = clamp_size(cfg.glyph_height);
  assign advance = !out_valid_r || out_chan.ready;
  assign issue   = (state_r == ST_ROWS) && (row_i_r < h) && (!fet_valid_r || advance);

  assign q_take   = (state_r == ST_IDLE) && q_valid;
  assign is_draw  = (q_entry.kind == OP_CHAR);
  assign store_we = q_take && (q_entry.kind == OP_LOAD_ROW);
  assign start_we = q_take && (q_entry.kind == OP_LOAD_START);
  assign start_re = q_take && is_draw;
  assign store_ra = start_rd_r[GW_AW-1:0] + GW_AW'(row_i_r);

  assign mul_a = cfg.portrait_layout ? q_entry.col : q_entry.row;
  assign step  = cfg.portrait_layout ? 24'd1 : 24'(cfg.line_pitch);

  // memories: written from loads, read with enable so data holds while stalled
  always_ff @(posedge clk) begin
    if (store_we) glyph_store[q_entry.index[GW_AW-1:0]] <= q_entry.data;
    if (issue)    word_rd_r <= glyph_store[store_ra];
  end

  always_ff @(posedge clk) begin
    if (start_we) glyph_start[q_entry.index[CS_AW-1:0]] <= q_entry.data[11:0];
    if (start_re) start_rd_r <= glyph_start[q_entry.index[CS_AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_take && is_draw) state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_ROWS;
      ST_ROWS: if (issue && (row_i_r + 5'd1 == h)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_re) begin
      col_r  <= q_entry.col;
      row_r  <= q_entry.row;
      prod_r <= 26'(mul_a) * 26'(cfg.line_pitch);
    end
    if (state_r == ST_ADDR) begin
      row_addr_r <= prod_r[23:0] +
                    24'(cfg.portrait_layout ? row_r : col_r);
    end else if (issue) begin
      row_addr_r <= row_addr_r + step;
    end
    if (issue) begin
      fet_addr_r <= row_addr_r;
      fet_last_r <= (row_i_r + 5'd1 == h);
    end
    if (advance && fet_valid_r) begin
      out_addr_r <= fet_addr_r;
      out_mask_r <= word_rd_r & glyph_mask(w);
      out_last_r <= fet_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_i_r     <= '0;
      fet_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ADDR) row_i_r <= '0;
      else if (issue)         row_i_r <= row_i_r + 5'd1;
      if (issue)        fet_valid_r <= 1'b1;
      else if (advance) fet_valid_r <= 1'b0;
      if (advance) out_valid_r <= fet_valid_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.row_address   = out_addr_r;
  assign out_chan.pixel_count   = w;
  assign out_chan.fore_mask     = out_mask_r;
  assign out_chan.step_by_pitch = cfg.portrait_layout;
  assign out_chan.fore_value    = cfg.fore_color;
  assign out_chan.back_value    = cfg.keep_behind ? 16'd0 : cfg.back_color;
  assign out_chan.copy_behind   = cfg.keep_behind;
  assign out_chan.last_row      = out_last_r;

endmodule

`default_nettype wire

### src/text_glyph_row_renderer.sv
// ---------------------------------------------------------------------------
// text_glyph_row_renderer: bitmap font character generator
// Turns a character word stream into framebuffer row-write commands.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        opcode, char_code, start_x, start_y,
//                                    table_index, table_data
//  out_chan  out  valid/ready        row_address, pixel_count, fore_mask,
//                                    step_by_pitch, fore_value, back_value,
//                                    copy_behind, last_row
//  cfg_*     in   cfg_we (no wait)   cfg_index, cfg_wdata
//
//  Back end: a drawn character goes through table lookup and base multiply,
//  address add, then one glyph-store row read per cycle while out_chan is not
//  stalled. Loads write the glyph memories in the back end; start words, newlines and
//  suppressed characters are handled in the front end alone.
//  Reset: rst_n synchronous; output is halted until the first start word.
//  Glyph memories are not cleared. Stalls: a 4-word queue parts front and back;
//  out_chan backpressure holds the row sequencer, queue-full holds in_chan.
//
`default_nettype none

module text_glyph_row_renderer (
  input  logic        clk,
  input  logic        rst_n,
  txg_in_if.sink      in_chan,
  txg_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import txg_pkg::*;

  txg_cfg_t   cfg_r;
  txg_entry_t push_entry, pop_entry;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_take;

  // configuration registers, reset to their documented defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_pitch      <= 13'd320;
      cfg_r.glyph_width     <= 5'd8;
      cfg_r.glyph_height    <= 5'd10;
      cfg_r.right_limit     <= 13'd320;
      cfg_r.portrait_layout <= 1'b0;
      cfg_r.fore_color      <= 16'hFFFF;
      cfg_r.back_color      <= 16'h0000;
      cfg_r.keep_behind     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_PITCH:   cfg_r.line_pitch      <= cfg_wdata[12:0];
        CFG_GLYPH_WIDTH:  cfg_r.glyph_width     <= cfg_wdata[4:0];
        CFG_GLYPH_HEIGHT: cfg_r.glyph_height    <= cfg_wdata[4:0];
        CFG_RIGHT_LIMIT:  cfg_r.right_limit     <= cfg_wdata[12:0];
        CFG_PORTRAIT:     cfg_r.portrait_layout <= cfg_wdata[0];
        CFG_FORE_COLOR:   cfg_r.fore_color      <= cfg_wdata;
        CFG_BACK_COLOR:   cfg_r.back_color      <= cfg_wdata;
        CFG_KEEP_BEHIND:  cfg_r.keep_behind     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // front: cursor tracking, halt on limit crossing, classification
  txg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg_r),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // loads travel through the queue too, so memory writes stay in order with draws
  txg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take)
  );

  // back: glyph memories, address generation, row emission
  txg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_entry  (pop_entry),
    .q_valid  (pop_valid),
    .q_take   (pop_take),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
